### src/rlkm_pkg.sv
// Package for the rating line key matcher.
// Holds the item modes, scan phase codes, character constants and the result type.
// No dependencies.
package rlkm_pkg;

    localparam int KEY_BYTES_DEF   = 256;
    localparam int OFFSET_BITS_DEF = 32;

    localparam int MODE_W = 2;
    localparam int BYTE_W = 8;
    localparam int KLEN_W = 9;
    localparam int POS_W  = 32;
    localparam int RAT_W  = 3;

    localparam logic [MODE_W-1:0] MODE_KEY  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TEXT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_END  = 2'd2;

    localparam logic [2:0] PH_LINE_START  = 3'd0;
    localparam logic [2:0] PH_AFTER_DIGIT = 3'd1;
    localparam logic [2:0] PH_MATCH       = 3'd2;
    localparam logic [2:0] PH_CHECK_END   = 3'd3;
    localparam logic [2:0] PH_SKIP        = 3'd4;
    localparam logic [2:0] PH_DONE        = 3'd5;

    localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CH_FIVE    = 8'h35;
    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0a;
    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic [RAT_W-1:0] rating;
        logic             found;
    } t_result;

endpackage

### src/rlkm_key_ram.sv
// Key byte store for the rating line key matcher.
// One write port and one registered read port with write-through on a same-address write.
// No dependencies.
module rlkm_key_ram #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [7:0]        o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/rlkm_out_queue.sv
// Two-entry result queue for the rating line key matcher.
// An output register and a skid register, so an item is taken while a result waits.
// Depends on rlkm_pkg.
module rlkm_out_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rlkm_pkg::t_result i_data,
    output logic             o_room,
    output logic             o_valid,
    input  logic             i_ready,
    output rlkm_pkg::t_result o_data
);

    logic              r_head_valid;
    logic              r_skid_valid;
    rlkm_pkg::t_result r_head;
    rlkm_pkg::t_result r_skid;
    logic              w_pop;

    assign w_pop = r_head_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_head_valid || w_pop) begin
            if (r_skid_valid) begin
                r_head_valid <= 1'b1;
                r_skid_valid <= i_push;
            end else begin
                r_head_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_head_valid || w_pop) begin
            if (r_skid_valid) begin
                r_head <= r_skid;
                r_skid <= i_data;
            end else begin
                r_head <= i_data;
            end
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

    assign o_room  = !r_skid_valid;
    assign o_valid = r_head_valid;
    assign o_data  = r_head;

endmodule

### src/rating_line_key_matcher.sv
// Rating line key matcher: finds the first line "D KEY" in a byte stream, D from 0 to 5.
// Top level; depends on rlkm_pkg, rlkm_key_ram and rlkm_out_queue.
//
// Usage. The key length is written through i_cfg_we/i_cfg_wdata while the block is idle.
// Key bytes are sent as items with mode 0 (tuser) and their index and byte in tdata.
// Text bytes follow with mode 1, one item per byte; an item with mode 2 ends the text
// and restarts the search. Each search gives exactly one result item: on the newline
// that ends the first matching line, or at the end of text when nothing was found or
// the match ran up to the end. The result carries the found flag in tuser and the
// rating and byte offset of the rating digit in tdata.
// Throughput is one item per cycle while the result queue has room: each byte needs one
// compare against the key byte, which is read ahead from the key memory in the cycle
// before it is needed. Results pass through the registered result queue to the master side.
// A two-entry result queue lets input items flow while a result waits; when both
// entries are full, s_axis_tready drops until the receiver takes a result.
// Reset clears the search state, the key length and the queue; the key memory keeps
// its contents and needs no clearing pass.
module rating_line_key_matcher #(
    parameter int KEY_BYTES   = rlkm_pkg::KEY_BYTES_DEF,
    parameter int OFFSET_BITS = rlkm_pkg::OFFSET_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // key_index [7:0], data_byte [15:8]
    input  logic [1:0]  s_axis_tuser,  // mode [1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // rating [2:0], rating_position [34:3], zeros
    output logic [0:0]  m_axis_tuser   // found [0]
);

    localparam int MATCH_W = $clog2(KEY_BYTES + 1);
    localparam int IDX_W   = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

    logic [rlkm_pkg::KLEN_W-1:0] r_key_length;
    logic [2:0]                  r_phase;
    logic [2:0]                  n_phase;
    logic [MATCH_W-1:0]          r_match;
    logic [MATCH_W-1:0]          n_match;
    logic [2:0]                  r_rating;
    logic [2:0]                  n_rating;
    logic [OFFSET_BITS-1:0]      r_offset;
    logic [OFFSET_BITS-1:0]      n_offset;
    logic [OFFSET_BITS-1:0]      r_cand;
    logic [OFFSET_BITS-1:0]      n_cand;

    logic              w_accept;
    logic [1:0]        w_mode;
    logic [7:0]        w_key_index;
    logic [7:0]        w_byte;
    logic [7:0]        w_key_byte;
    logic [MATCH_W-1:0] w_len;
    logic              w_match_full;
    logic              w_key_we;
    logic              w_emit;
    logic              w_hit;
    logic [MATCH_W-1:0] w_match_inc;
    logic [63:0]       w_cand_ext;
    logic              w_room;
    rlkm_pkg::t_result w_res;
    rlkm_pkg::t_result w_out;

    assign w_accept    = s_axis_tvalid && s_axis_tready;
    assign w_mode      = s_axis_tuser;
    assign w_key_index = s_axis_tdata[7:0];
    assign w_byte      = s_axis_tdata[15:8];
    assign s_axis_tready = w_room;

    assign w_len = (32'(r_key_length) > KEY_BYTES) ? MATCH_W'(KEY_BYTES)
                                                   : MATCH_W'(r_key_length);
    assign w_match_full = (r_match >= w_len);
    assign w_match_inc  = MATCH_W'(r_match + 1'b1);
    assign w_key_we = w_accept && (w_mode == rlkm_pkg::MODE_KEY)
                      && (32'(w_key_index) < KEY_BYTES);
    assign w_cand_ext = 64'(r_cand);

    always_comb begin
        n_phase  = r_phase;
        n_match  = r_match;
        n_rating = r_rating;
        n_offset = r_offset;
        n_cand   = r_cand;
        w_emit   = 1'b0;
        w_hit    = 1'b0;
        if (w_accept && (w_mode == rlkm_pkg::MODE_TEXT)) begin
            case (r_phase)
                rlkm_pkg::PH_LINE_START: begin
                    if ((w_byte >= rlkm_pkg::CH_ZERO) && (w_byte <= rlkm_pkg::CH_FIVE)) begin
                        n_rating = 3'(w_byte - rlkm_pkg::CH_ZERO);
                        n_cand   = r_offset;
                        n_phase  = rlkm_pkg::PH_AFTER_DIGIT;
                    end else if (w_byte != rlkm_pkg::CH_NEWLINE) begin
                        n_phase = rlkm_pkg::PH_SKIP;
                    end
                end
                rlkm_pkg::PH_AFTER_DIGIT: begin
                    if (w_byte == rlkm_pkg::CH_NEWLINE) begin
                        n_phase = rlkm_pkg::PH_LINE_START;
                    end else if (w_byte == rlkm_pkg::CH_SPACE) begin
                        n_match = '0;
                        n_phase = (w_len == '0) ? rlkm_pkg::PH_CHECK_END
                                                : rlkm_pkg::PH_MATCH;
                    end else begin
                        n_phase = rlkm_pkg::PH_SKIP;
                    end
                end
                rlkm_pkg::PH_MATCH: begin
                    if (w_match_full) begin
                        if (w_byte == rlkm_pkg::CH_NEWLINE) begin
                            w_emit  = 1'b1;
                            w_hit   = 1'b1;
                            n_phase = rlkm_pkg::PH_DONE;
                        end else begin
                            n_phase = rlkm_pkg::PH_SKIP;
                        end
                    end else if (w_key_byte == w_byte) begin
                        n_match = w_match_inc;
                        if (w_match_inc >= w_len) begin
                            n_phase = rlkm_pkg::PH_CHECK_END;
                        end
                    end else begin
                        n_phase = (w_byte == rlkm_pkg::CH_NEWLINE) ? rlkm_pkg::PH_LINE_START
                                                                   : rlkm_pkg::PH_SKIP;
                    end
                end
                rlkm_pkg::PH_CHECK_END: begin
                    if (w_byte == rlkm_pkg::CH_NEWLINE) begin
                        w_emit  = 1'b1;
                        w_hit   = 1'b1;
                        n_phase = rlkm_pkg::PH_DONE;
                    end else begin
                        n_phase = rlkm_pkg::PH_SKIP;
                    end
                end
                rlkm_pkg::PH_SKIP: begin
                    if (w_byte == rlkm_pkg::CH_NEWLINE) begin
                        n_phase = rlkm_pkg::PH_LINE_START;
                    end
                end
                default: begin
                end
            endcase
            if (r_offset != '1) begin
                n_offset = r_offset + 1'b1;
            end
        end else if (w_accept && (w_mode == rlkm_pkg::MODE_END)) begin
            w_emit   = (r_phase != rlkm_pkg::PH_DONE);
            w_hit    = (r_phase == rlkm_pkg::PH_CHECK_END)
                       || ((r_phase == rlkm_pkg::PH_MATCH) && w_match_full);
            n_phase  = rlkm_pkg::PH_LINE_START;
            n_match  = '0;
            n_rating = '0;
            n_offset = '0;
            n_cand   = '0;
        end
    end

    always_comb begin
        w_res.found    = w_hit;
        w_res.rating   = w_hit ? r_rating : '0;
        w_res.position = w_hit ? w_cand_ext[rlkm_pkg::POS_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_length <= '0;
            r_phase      <= rlkm_pkg::PH_LINE_START;
            r_match      <= '0;
            r_rating     <= '0;
            r_offset     <= '0;
            r_cand       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_key_length <= i_cfg_wdata;
            end
            r_phase  <= n_phase;
            r_match  <= n_match;
            r_rating <= n_rating;
            r_offset <= n_offset;
            r_cand   <= n_cand;
        end
    end

    rlkm_key_ram #(
        .DEPTH  (KEY_BYTES),
        .ADDR_W (IDX_W)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_key_we),
        .i_waddr (IDX_W'(w_key_index)),
        .i_wdata (w_byte),
        .i_raddr (n_match[IDX_W-1:0]),
        .o_rdata (w_key_byte)
    );

    rlkm_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_emit),
        .i_data  (w_res),
        .o_room  (w_room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (w_out)
    );

    assign m_axis_tdata = {5'd0, w_out.position, w_out.rating};
    assign m_axis_tuser = w_out.found;

    a_found_rating: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[2:0] <= 3'd5))
        else $error("Found result carries a rating above five.");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("Not-found result carries a non-zero rating or position.");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("Input side stalled while no result is waiting.");

    a_match_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == rlkm_pkg::PH_MATCH) |-> (32'(r_match) <= KEY_BYTES))
        else $error("Key match index ran past the key store.");

endmodule
